[rtl/wppf_pkg.sv]
// Package: shared widths, constants, register codes and the result type of the pulse peak finder.
`default_nettype none

package wppf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 13;
  localparam int LIMIT_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // Wall level of -400.0 in Q12.4.
  localparam logic signed [SAMPLE_W-1:0] WALL_LEVEL = -16'sd6400;

  localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = 16'sd32;
  localparam logic [CNT_W-1:0]           MIN_WIDTH_RST = 13'd5;
  localparam logic [CNT_W-1:0]           CNT_MAX       = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD     = 3'd0,
    CFG_MIN_WIDTH     = 3'd1,
    CFG_HIT_LIMIT     = 3'd2,
    CFG_HIT_LIMIT_OFF = 3'd3,
    CFG_WALL_MODE     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] peak_index;
    logic             is_end;
    logic [CNT_W-1:0] hit_count;
  } result_t;

endpackage

`default_nettype wire

[rtl/wppf_if.sv]
// Interfaces: the sample request channel and the result request channel.
`default_nettype none

interface wppf_sample_if;
  import wppf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       end_of_wave;

  modport source (output valid, output sample, output end_of_wave, input ready);
  modport sink   (input valid, input sample, input end_of_wave, output ready);
endinterface

interface wppf_result_if;
  import wppf_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] peak_index;
  logic             is_end;
  logic [CNT_W-1:0] hit_count;

  modport source (output valid, output peak_index, output is_end, output hit_count,
                  input ready);
  modport sink   (input valid, input peak_index, input is_end, input hit_count,
                  output ready);
endinterface

`default_nettype wire

[rtl/waveform_pulse_peak_finder.sv]
// Top level: threshold and width pulse peak finder with wall mode and a result queue.
// Each result is written into the result queue as its sample request is accepted.
// Throughput: one sample per cycle; the result side moves one result per cycle, and a
// sample that closes a pulse on the last sample of a waveform yields two results.
// Samples stall only when the four-entry result queue lacks room for two results.
// Reset (rst, synchronous, active high) restores the register defaults and clears
// all per-waveform state and the result queue.
`default_nettype none

module waveform_pulse_peak_finder (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_write,
  input  wire [wppf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [wppf_pkg::CFG_W-1:0]         cfg_data,
  wppf_sample_if.sink                       samples,
  wppf_result_if.source                     results
);
  import wppf_pkg::*;

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] threshold;
  logic [CNT_W-1:0]           min_width;
  logic [LIMIT_W-1:0]         hit_limit;
  logic                       hit_limit_off;
  logic                       wall_mode;

  // Per-waveform tracking state.
  logic [IDX_W-1:0]           sample_index;
  logic [CNT_W-1:0]           run_length;
  logic                       in_pulse;
  logic signed [SAMPLE_W-1:0] running_min;
  logic [IDX_W-1:0]           min_position;
  logic [CNT_W-1:0]           hits_reported;
  logic                       wall_found;

  logic [IDX_W-1:0]           sample_index_next;
  logic [CNT_W-1:0]           run_length_next;
  logic                       in_pulse_next;
  logic signed [SAMPLE_W-1:0] running_min_next;
  logic [IDX_W-1:0]           min_position_next;
  logic [CNT_W-1:0]           hits_reported_next;
  logic                       wall_found_next;

  // Result queue: four entries, so that a two-result sample always fits once
  // the queue holds two or fewer entries.
  result_t    queue [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  logic    accept;
  logic    pop;
  logic    hit;
  result_t hit_res;
  result_t end_res;
  result_t res0;
  result_t res1;
  logic [1:0] push_n;

  assign accept = samples.valid && samples.ready;
  assign pop    = results.valid && results.ready;

  // Room for two results is required before a sample request is taken.
  assign samples.ready = (count <= 3'd2);

  // Configuration writes land directly in their registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESHOLD_RST;
      min_width     <= MIN_WIDTH_RST;
      hit_limit     <= '0;
      hit_limit_off <= 1'b0;
      wall_mode     <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_THRESHOLD:     threshold     <= cfg_data[SAMPLE_W-1:0];
        CFG_MIN_WIDTH:     min_width     <= cfg_data[CNT_W-1:0];
        CFG_HIT_LIMIT:     hit_limit     <= cfg_data[LIMIT_W-1:0];
        CFG_HIT_LIMIT_OFF: hit_limit_off <= cfg_data[0];
        CFG_WALL_MODE:     wall_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Single-pass update of the tracking state for the sample on the channel.
  // In wall mode only the first crossing below the wall level counts. In pulse
  // mode a run below threshold tracks its earliest minimum, and the closing
  // sample reports that position if the run was long enough and the hit limit
  // allows it. The last sample of a waveform appends an end marker and clears
  // all per-waveform state.
  always_comb begin
    sample_index_next  = sample_index;
    run_length_next    = run_length;
    in_pulse_next      = in_pulse;
    running_min_next   = running_min;
    min_position_next  = min_position;
    hits_reported_next = hits_reported;
    wall_found_next    = wall_found;
    hit                = 1'b0;
    hit_res            = '0;

    if (wall_mode) begin
      if (!wall_found && (samples.sample < WALL_LEVEL)) begin
        wall_found_next = 1'b1;
        hit             = 1'b1;
        if (hits_reported < CNT_MAX) begin
          hits_reported_next = hits_reported + 1'b1;
        end
        hit_res.peak_index = sample_index;
      end
    end else if (samples.sample < threshold) begin
      if (!in_pulse || (samples.sample < running_min)) begin
        running_min_next  = samples.sample;
        min_position_next = sample_index;
      end
      in_pulse_next = 1'b1;
      if (run_length < CNT_MAX) begin
        run_length_next = run_length + 1'b1;
      end
    end else begin
      if (in_pulse && (run_length >= min_width) &&
          (hit_limit_off || (hits_reported < {{(CNT_W-LIMIT_W){1'b0}}, hit_limit}))) begin
        hit = 1'b1;
        if (hits_reported < CNT_MAX) begin
          hits_reported_next = hits_reported + 1'b1;
        end
        hit_res.peak_index = min_position;
      end
      in_pulse_next     = 1'b0;
      run_length_next   = '0;
      running_min_next  = '0;
      min_position_next = '0;
    end
    hit_res.is_end    = 1'b0;
    hit_res.hit_count = hits_reported_next;

    end_res.peak_index = '0;
    end_res.is_end     = 1'b1;
    end_res.hit_count  = hits_reported_next;

    if (samples.end_of_wave) begin
      sample_index_next  = '0;
      run_length_next    = '0;
      in_pulse_next      = 1'b0;
      running_min_next   = '0;
      min_position_next  = '0;
      hits_reported_next = '0;
      wall_found_next    = 1'b0;
    end else begin
      sample_index_next = sample_index + 1'b1;
    end

    // Results in order: the hit first, then the end marker.
    res0   = hit ? hit_res : end_res;
    res1   = end_res;
    push_n = {1'b0, hit} + {1'b0, samples.end_of_wave};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index  <= '0;
      run_length    <= '0;
      in_pulse      <= 1'b0;
      running_min   <= '0;
      min_position  <= '0;
      hits_reported <= '0;
      wall_found    <= 1'b0;
    end else if (accept) begin
      sample_index  <= sample_index_next;
      run_length    <= run_length_next;
      in_pulse      <= in_pulse_next;
      running_min   <= running_min_next;
      min_position  <= min_position_next;
      hits_reported <= hits_reported_next;
      wall_found    <= wall_found_next;
    end
  end

  // Queue storage carries no reset; only the pointers and the count do.
  always_ff @(posedge clk) begin
    if (accept && (push_n != 2'd0)) begin
      queue[wr_ptr] <= res0;
    end
    if (accept && (push_n == 2'd2)) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + push_n;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (accept ? {1'b0, push_n} : 3'd0) - {2'b0, pop};
    end
  end

  assign results.valid      = (count != 3'd0);
  assign results.peak_index = queue[rd_ptr].peak_index;
  assign results.is_end     = queue[rd_ptr].is_end;
  assign results.hit_count  = queue[rd_ptr].hit_count;

endmodule

`default_nettype wire

[rtl/wppf_checker.sv]
// Checker: port-level assertions for the pulse peak finder, bound to the top level.
`default_nettype none

module wppf_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         in_valid,
  input wire                         in_ready,
  input wire                         in_end_of_wave,
  input wire                         out_valid,
  input wire                         out_ready,
  input wire [wppf_pkg::IDX_W-1:0]   out_peak_index,
  input wire                         out_is_end,
  input wire [wppf_pkg::CNT_W-1:0]   out_hit_count
);
  import wppf_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_peak_index) &&
      $stable(out_is_end) && $stable(out_hit_count))
    else $error("result changed while stalled");

  // The last sample of a waveform always leaves a result waiting.
  a_end_queued: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_end_of_wave |=> out_valid)
    else $error("no result after last sample");

  // End markers carry a zero index.
  a_end_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_is_end |-> out_peak_index == '0)
    else $error("end marker with nonzero index");

  // A reported hit is counted, so its count is never zero.
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_is_end |-> out_hit_count != '0)
    else $error("hit with zero count");

endmodule

bind waveform_pulse_peak_finder wppf_checker u_wppf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (samples.valid),
  .in_ready       (samples.ready),
  .in_end_of_wave (samples.end_of_wave),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .out_peak_index (results.peak_index),
  .out_is_end     (results.is_end),
  .out_hit_count  (results.hit_count)
);

`default_nettype wire

[tb/sv/waveform_pulse_peak_finder_checker.sv]
// Checker: watches the sample and result channels, predicts every result and compares it.
module waveform_pulse_peak_finder_checker
  import wppf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  wppf_sample_if               samples,
  wppf_result_if               results,
  output int                   mismatches,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies.
  logic signed [SAMPLE_W-1:0] thr;
  logic [CNT_W-1:0]           min_len;
  logic [LIMIT_W-1:0]         limit;
  logic                       limit_off;
  logic                       wall_on;

  // Per-waveform tracking state.
  logic [IDX_W-1:0]           wave_pos;
  logic [CNT_W-1:0]           below_count;
  logic                       in_run;
  logic signed [SAMPLE_W-1:0] run_min;
  logic [IDX_W-1:0]           run_min_pos;
  logic [CNT_W-1:0]           hits;
  logic                       wall_seen;

  result_t peaks_due[$];

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  function automatic result_t make_result(input logic [IDX_W-1:0] idx, input logic last,
                                          input logic [CNT_W-1:0] cnt);
    result_t r;
    r.peak_index = idx;
    r.is_end     = last;
    r.hit_count  = cnt;
    return r;
  endfunction

  // Appends one predicted result behind all older ones.
  task automatic queue_expected(input result_t r);
    peaks_due = {peaks_due, r};
  endtask

  task automatic clear_wave();
    wave_pos    = '0;
    below_count = '0;
    in_run      = 1'b0;
    run_min     = '0;
    run_min_pos = '0;
    hits        = '0;
    wall_seen   = 1'b0;
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (cfg_reg_t'(idx))
      CFG_THRESHOLD:     thr       = data;
      CFG_MIN_WIDTH:     min_len   = data[CNT_W-1:0];
      CFG_HIT_LIMIT:     limit     = data[LIMIT_W-1:0];
      CFG_HIT_LIMIT_OFF: limit_off = data[0];
      CFG_WALL_MODE:     wall_on   = data[0];
      default: ;
    endcase
  endtask

  // Advances the tracking state by one sample and queues the results it causes.
  task automatic track_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    if (wall_on) begin
      if (!wall_seen && s < WALL_LEVEL) begin
        wall_seen = 1'b1;
        if (hits != CNT_MAX) hits++;
        queue_expected(make_result(wave_pos, 1'b0, hits));
      end
    end else if (s < thr) begin
      if (!in_run || s < run_min) begin
        run_min     = s;
        run_min_pos = wave_pos;
      end
      in_run = 1'b1;
      if (below_count != CNT_MAX) below_count++;
    end else begin
      if (in_run && below_count >= min_len && (limit_off || hits < limit)) begin
        if (hits != CNT_MAX) hits++;
        queue_expected(make_result(run_min_pos, 1'b0, hits));
      end
      in_run      = 1'b0;
      below_count = '0;
      run_min     = '0;
      run_min_pos = '0;
    end

    if (last) begin
      queue_expected(make_result('0, 1'b1, hits));
      clear_wave();
    end else begin
      wave_pos++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (peaks_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected result index %0d end %0b count %0d",
                              got.peak_index, got.is_end, got.hit_count));
      return;
    end
    want = peaks_due.pop_front();
    if (got.peak_index !== want.peak_index)
      flag_mismatch($sformatf("peak_index %0d, predicted %0d", got.peak_index,
                              want.peak_index));
    if (got.is_end !== want.is_end)
      flag_mismatch($sformatf("is_end %0b, predicted %0b", got.is_end, want.is_end));
    if (got.hit_count !== want.hit_count)
      flag_mismatch($sformatf("hit_count %0d, predicted %0d", got.hit_count,
                              want.hit_count));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      thr       = THRESHOLD_RST;
      min_len   = MIN_WIDTH_RST;
      limit     = '0;
      limit_off = 1'b0;
      wall_on   = 1'b0;
      clear_wave();
      peaks_due.delete();
    end else begin
      if (cfg_write) apply_register(cfg_index, cfg_data);
      // New expectations go to the back first; a result taken at this edge is always older.
      if (samples.valid && samples.ready) track_sample(samples.sample, samples.end_of_wave);
      if (results.valid && results.ready)
        check_result(make_result(results.peak_index, results.is_end, results.hit_count));
    end
    outstanding = peaks_due.size();
  end

endmodule

[tb/sv/waveform_pulse_peak_finder_tb.sv]
// Testbench top: clock, reset, register writes, sample stimulus, result stalls and the verdict.
module waveform_pulse_peak_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wppf_pkg::*;

  // Number of random samples after the directed part.
  localparam int RANDOM_ITEMS = 900;
  // The run carries roughly 2k samples; even with every sample gapped and every result
  // stalled to the longest this stays well below the limit.
  localparam int CYCLE_LIMIT  = 200_000;
  // Cycles allowed for a sample still inside the block once no result is pending.
  localparam int SETTLE       = 4;

  // Receiver behaviors.
  localparam int RX_OPEN   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_BURSTY = 2;

  // Kinds of generated waveforms.
  localparam int WAVE_PULSE = 0;
  localparam int WAVE_WALL  = 1;
  localparam int WAVE_NOISE = 2;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  cfg_reg_t             cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  wppf_sample_if sample_ch ();
  wppf_result_if result_ch ();

  int mismatches;
  int pending;
  int cycles;
  int items_sent;
  int burst_left;

  // Shadows of the registers, used to aim the samples at the current threshold.
  int cur_threshold;
  int cur_min_width;
  bit cur_wall;

  int rx_mode;
  int rx_cycle;
  int stall_left;

  waveform_pulse_peak_finder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_ch),
    .results   (result_ch)
  );

  waveform_pulse_peak_finder_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .samples     (sample_ch),
    .results     (result_ch),
    .mismatches  (mismatches),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The result side stalls on its own pattern. At regular intervals it picks a new
  // behavior: always ready, a coin flip per cycle, or ready with occasional stall runs.
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(RX_OPEN, RX_BURSTY);
    if (stall_left != 0) begin
      stall_left--;
      result_ch.ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: result_ch.ready = 1'b1;
        RX_COIN: result_ch.ready = 1'($urandom_range(0, 1));
        default: begin
          result_ch.ready = 1'b1;
          if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
        end
      endcase
    end
  end

  // Offers one sample request and returns once it has been accepted. The sender works in
  // bursts; between bursts valid drops for a random gap, and some bursts follow with no gap.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        sample_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
    end
    sample_ch.valid       = 1'b1;
    sample_ch.sample      = value;
    sample_ch.end_of_wave = last;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Holds the sender until every predicted result has come out and the block has settled.
  task automatic drain();
    sample_ch.valid = 1'b0;
    burst_left      = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_W-1:0];
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Registers change only with the block idle, so every write is preceded by a drain.
  task automatic configure(input int thr, input int mw, input int lim, input bit off,
                           input bit wall);
    drain();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_MIN_WIDTH, mw);
    write_reg(CFG_HIT_LIMIT, lim);
    write_reg(CFG_HIT_LIMIT_OFF, int'(off));
    write_reg(CFG_WALL_MODE, int'(wall));
    cur_threshold = thr;
    cur_min_width = mw;
    cur_wall      = wall;
  endtask

  // A value just under the threshold most of the time, so that equal minima are common,
  // and now and then far under it.
  function automatic logic signed [SAMPLE_W-1:0] below_level();
    int v;
    v = cur_threshold - 1 -
        (($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 20000)) : int'($urandom_range(0, 6)));
    if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] above_level();
    int v;
    v = cur_threshold + int'($urandom_range(0, 40));
    if (v > 32767) v = 32767;
    return v[SAMPLE_W-1:0];
  endfunction

  // Values around the wall level (also exactly on it), random nonpositive values, and -32768.
  function automatic logic signed [SAMPLE_W-1:0] wall_level_sample();
    int v;
    case ($urandom_range(0, 3))
      0:       v = -32768;
      1:       v = -int'($urandom_range(0, 32768));
      default: v = WALL_LEVEL + int'($urandom_range(0, 6)) - 3;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // Sends one waveform of the given length as alternating stretches above and below the
  // level of interest. Low stretches in pulse waves sit around min_width so that runs are
  // just short, just long enough and a little longer. A cut waveform has no last sample,
  // so the next phase continues it under new register settings.
  task automatic send_wave(input int length, input bit cut, input int style);
    int n;
    int k;
    int seg;
    bit low;
    logic signed [SAMPLE_W-1:0] value;
    n   = 0;
    low = 1'($urandom_range(0, 1));
    while (n < length) begin
      if (low && style == WAVE_PULSE && cur_min_width <= 16 && $urandom_range(0, 3) != 0)
        seg = cur_min_width + int'($urandom_range(0, 3)) - 1;
      else if (low)
        seg = $urandom_range(1, 12);
      else
        seg = $urandom_range(1, 4);
      if (seg < 1) seg = 1;
      for (k = 0; k < seg && n < length; k++) begin
        if (style == WAVE_NOISE)
          value = 16'($urandom_range(0, 65535));
        else if (low)
          value = (style == WAVE_WALL) ? wall_level_sample() : below_level();
        else
          value = above_level();
        send_sample(value, (n == length - 1) && !cut);
        n++;
      end
      low = !low;
    end
  endtask

  initial begin
    int style;
    int thr;
    int mw;
    int lim;
    bit off;
    bit wall;
    int goal;
    int i;

    rst                   = 1'b1;
    cfg_write             = 1'b0;
    cfg_index             = CFG_THRESHOLD;
    cfg_data              = '0;
    sample_ch.valid       = 1'b0;
    sample_ch.sample      = '0;
    sample_ch.end_of_wave = 1'b0;
    result_ch.ready       = 1'b0;
    cycles                = 0;
    items_sent            = 0;
    burst_left            = 0;
    rx_mode               = RX_OPEN;
    rx_cycle              = 0;
    stall_left            = 0;
    cur_threshold         = int'(THRESHOLD_RST);
    cur_min_width         = int'(MIN_WIDTH_RST);
    cur_wall              = 1'b0;

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Reset settings: the hit limit of zero keeps even a full-width pulse from being
    // reported. The last sample opens a run that is dropped with the waveform.
    send_sample(16'sd20, 1'b0);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd3, 1'b0);
    send_sample(16'sd32, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b1);

    // Limit of one pulse: the first pulse has a tie for its minimum and closes on a sample
    // equal to the threshold; the second is valid but over the limit; the third is short.
    configure(0, 2, 1, 1'b0, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(-16'sd9, 1'b0);
    send_sample(-16'sd9, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b0);
    send_sample(16'sd7, 1'b0);
    send_sample(-16'sd4, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd32767, 1'b1);

    // With the limit off, a pulse closed by the last sample gives a hit and the marker.
    configure(0, 2, 1, 1'b1, 1'b0);
    send_sample(-16'sd7, 1'b0);
    send_sample(-16'sd8, 1'b0);
    send_sample(16'sd5, 1'b1);

    // Wall mode: the wall level itself does not count, only the first crossing is reported.
    configure(0, 2, 1, 1'b1, 1'b1);
    send_sample(-16'sd6400, 1'b0);
    send_sample(-16'sd6401, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd100, 1'b1);

    // Random phases. Each picks fresh settings with the extremes well represented and sends
    // a few waveforms; some phases end mid-waveform, so the next one changes the mode or
    // the threshold while a waveform is open.
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      case ($urandom_range(0, 7))
        0:       thr = -32768;
        1:       thr = 32767;
        2:       thr = 0;
        3:       thr = int'($urandom_range(0, 65535)) - 32768;
        default: thr = int'($urandom_range(0, 200)) - 100;
      endcase
      case ($urandom_range(0, 5))
        0:       mw = 0;
        1:       mw = 1;
        2:       mw = 4096;
        default: mw = $urandom_range(2, 10);
      endcase
      case ($urandom_range(0, 3))
        0:       lim = 0;
        1:       lim = 255;
        default: lim = $urandom_range(1, 4);
      endcase
      off  = 1'($urandom_range(0, 1));
      wall = ($urandom_range(0, 3) == 0);
      configure(thr, mw, lim, off, wall);

      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 4) == 0) style = WAVE_NOISE;
        else                           style = cur_wall ? WAVE_WALL : WAVE_PULSE;
        send_wave($urandom_range(1, 40), 1'b0, style);
      end
      if ($urandom_range(0, 2) == 0)
        send_wave($urandom_range(1, 20), 1'b1, cur_wall ? WAVE_WALL : WAVE_PULSE);
    end

    // Wide pulse setting. The first run lasts well past the minimum width and holds the
    // most negative sample in its middle. Then a run of exactly the minimum width and one
    // a sample short follow.
    configure(0, 64, 0, 1'b1, 1'b0);
    repeat (5) send_sample(16'sd100, 1'b0);
    for (i = 0; i < 150; i++)
      send_sample((i == 70) ? -16'sd32768 : -16'(int'($urandom_range(1, 1000))), 1'b0);
    send_sample(16'sd50, 1'b0);
    repeat (64) send_sample(-16'(int'($urandom_range(1, 50))), 1'b0);
    send_sample(16'sd1, 1'b0);
    repeat (63) send_sample(-16'(int'($urandom_range(1, 50))), 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);

    // Hit counting: one-sample pulses under the largest limit stop counting at 255; the
    // limit is then switched off mid-waveform and the count keeps climbing.
    configure(0, 0, 255, 1'b0, 1'b0);
    repeat (260) begin
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b0);
    end
    configure(0, 0, 255, 1'b1, 1'b0);
    repeat (20) begin
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b0);
    end
    send_sample(16'sd0, 1'b1);

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
